### design/ksr_pkg.sv
// Package for the keyboard state router: request and result codes, slot-list
// control types, sequencer states and the modifier lookup.
// No dependencies.
`timescale 1ns / 1ps

package ksr_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int CNT_W     = $clog2(KEY_SLOTS + 1);
    localparam int IDX_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    localparam logic [7:0] ALL_UP_FLAGS = 8'hFF;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [2:0] {
        REQ_KEY_DOWN   = 3'd0,
        REQ_KEY_UP     = 3'd1,
        REQ_OTHER      = 3'd2,
        REQ_TO_HOST    = 3'd3,
        REQ_TO_CLIENT  = 3'd4,
        REQ_TOGGLE     = 3'd5,
        REQ_CONNECT    = 3'd6,
        REQ_DISCONNECT = 3'd7
    } t_req;

    typedef enum logic [2:0] {
        KIND_KEY_DOWN   = 3'd0,
        KIND_KEY_UP     = 3'd1,
        KIND_OTHER      = 3'd2,
        KIND_ALL_UP     = 3'd3,
        KIND_MOUSE_IDLE = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        L_NOP,
        L_CLEAR,
        L_APPEND,
        L_SHIFT,
        L_DROP
    } t_list_op;

    typedef struct packed {
        t_list_op op;
        t_cnt     idx;
    } t_list_ctrl;

    typedef struct packed {
        t_cnt used;
        logic hit;
    } t_list_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_EMIT,
        S_FLUSH_UP,
        S_FLUSH_IDLE
    } t_state;

    // HID modifier bit for the eight mapped virtual keys, zero otherwise
    function automatic logic [7:0] modifier_mask(input logic [15:0] vk);
        logic [7:0] m;
        unique case (vk)
            16'h00A2: m = 8'h01;
            16'h00A0: m = 8'h02;
            16'h00A4: m = 8'h04;
            16'h005B: m = 8'h08;
            16'h00A3: m = 8'h10;
            16'h00A1: m = 8'h20;
            16'h00A5: m = 8'h40;
            16'h005C: m = 8'h80;
            default:  m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

### design/keyboard_state_router_top.sv
// Keyboard state router top level: stream ports, sequencer, modifier state
// and result register. Depends on ksr_pkg and ksr_key_list.
`timescale 1ns / 1ps

// Takes one event per input transfer and sends key, other and flush events on
// to the client side while keeping the held modifiers and up to KEY_SLOTS held
// scan codes. s_axis_tready is high only while the sequencer is idle. A state-
// only request (connect, disconnect, routing change without flush, dropped
// event) returns the sequencer straight to idle; an other event passes
// through the emit state; leaving client mode emits its two flush transfers;
// a key down or a key up has one byte comparator walk the slot list a slot
// per cycle, and a removal then moves only the slots after the match down,
// one per cycle. A wait on m_axis_tready holds the sequencer in its emit and
// flush states.
module keyboard_state_router_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // scan_code[7:0], virtual_key[23:8], key_flags[31:24], event_payload[79:32]
    input  logic [79:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_scan_code[7:0], out_virtual_key[23:8], out_flags[31:24],
    // out_payload[79:32], held_modifiers[87:80], held_count[90:88], zero above
    output logic [95:0] m_axis_tdata,
    // out_kind[2:0]
    output logic [2:0]  m_axis_tuser,
    // last_of_run
    output logic        m_axis_tlast
);

    ksr_pkg::t_state r_state, n_state;
    logic            r_to_client, n_to_client;
    logic            r_link_up, n_link_up;
    logic [7:0]      r_mods, n_mods;
    ksr_pkg::t_cnt   r_idx, n_idx;

    ksr_pkg::t_req   r_req;
    logic [7:0]      r_sc;
    logic [15:0]     r_vk;
    logic [7:0]      r_fl;
    logic [47:0]     r_pl;

    logic            r_m_valid;
    ksr_pkg::t_kind  r_m_kind, n_m_kind;
    logic [95:0]     r_m_data, n_m_data;
    logic            r_m_last, n_m_last;
    logic            out_load;

    ksr_pkg::t_list_ctrl list_ctrl;
    ksr_pkg::t_list_stat list_stat;

    ksr_pkg::t_req   in_req;
    logic            s_fire;
    logic            fwd;
    logic            is_key;
    logic            go_host;
    logic            out_free;
    logic            at_end;
    logic            shift_more;
    ksr_pkg::t_cnt   idx_inc;
    logic [7:0]      in_mask;

    assign in_req   = ksr_pkg::t_req'(s_axis_tuser);
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign fwd      = r_to_client && r_link_up;
    assign is_key   = (in_req == ksr_pkg::REQ_KEY_DOWN) || (in_req == ksr_pkg::REQ_KEY_UP);
    assign go_host  = r_to_client &&
                      ((in_req == ksr_pkg::REQ_TO_HOST) || (in_req == ksr_pkg::REQ_TOGGLE));
    assign out_free = !r_m_valid || m_axis_tready;
    assign idx_inc  = ksr_pkg::t_cnt'(r_idx + ksr_pkg::t_cnt'(1));
    assign at_end   = (r_idx == list_stat.used);
    assign shift_more = (idx_inc < list_stat.used);
    assign in_mask  = ksr_pkg::modifier_mask(s_axis_tdata[23:8]);

    assign s_axis_tready = (r_state == ksr_pkg::S_IDLE);

    ksr_key_list u_key_list (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (list_ctrl),
        .i_scan_code (r_sc),
        .o_stat      (list_stat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ksr_pkg::S_IDLE: begin
                if (s_fire) begin
                    priority if (fwd && is_key)                      n_state = ksr_pkg::S_SCAN;
                    else if (fwd && in_req == ksr_pkg::REQ_OTHER)    n_state = ksr_pkg::S_EMIT;
                    else if (go_host)                                n_state = ksr_pkg::S_FLUSH_UP;
                    else                                             n_state = ksr_pkg::S_IDLE;
                end
            end
            ksr_pkg::S_SCAN: begin
                priority if (at_end)                 n_state = ksr_pkg::S_EMIT;
                else if (list_stat.hit)
                    n_state = (r_req == ksr_pkg::REQ_KEY_DOWN) ? ksr_pkg::S_EMIT
                                                               : ksr_pkg::S_SHIFT;
                else                                 n_state = ksr_pkg::S_SCAN;
            end
            ksr_pkg::S_SHIFT: begin
                if (!shift_more) n_state = ksr_pkg::S_EMIT;
            end
            ksr_pkg::S_EMIT: begin
                if (out_free) n_state = ksr_pkg::S_IDLE;
            end
            ksr_pkg::S_FLUSH_UP: begin
                if (out_free) n_state = ksr_pkg::S_FLUSH_IDLE;
            end
            ksr_pkg::S_FLUSH_IDLE: begin
                if (out_free) n_state = ksr_pkg::S_IDLE;
            end
            default: n_state = ksr_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        n_to_client   = r_to_client;
        n_link_up     = r_link_up;
        n_mods        = r_mods;
        n_idx         = r_idx;
        list_ctrl.op  = ksr_pkg::L_NOP;
        list_ctrl.idx = r_idx;
        out_load      = 1'b0;
        n_m_kind      = ksr_pkg::KIND_OTHER;
        n_m_data      = '0;
        n_m_last      = 1'b1;
        unique case (r_state)
            ksr_pkg::S_IDLE: begin
                n_idx = '0;
                if (s_fire) begin
                    unique case (in_req)
                        ksr_pkg::REQ_KEY_DOWN: begin
                            if (fwd) n_mods = r_mods | in_mask;
                        end
                        ksr_pkg::REQ_KEY_UP: begin
                            if (fwd) n_mods = r_mods & ~in_mask;
                        end
                        ksr_pkg::REQ_TO_HOST, ksr_pkg::REQ_TOGGLE: begin
                            if (r_to_client) begin
                                n_to_client  = 1'b0;
                                n_mods       = '0;
                                list_ctrl.op = ksr_pkg::L_CLEAR;
                            end else if (in_req == ksr_pkg::REQ_TOGGLE && r_link_up) begin
                                n_to_client = 1'b1;
                            end
                        end
                        ksr_pkg::REQ_TO_CLIENT: begin
                            if (r_link_up) n_to_client = 1'b1;
                        end
                        ksr_pkg::REQ_CONNECT: begin
                            n_link_up = 1'b1;
                        end
                        ksr_pkg::REQ_DISCONNECT: begin
                            n_link_up   = 1'b0;
                            n_to_client = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ksr_pkg::S_SCAN: begin
                if (at_end) begin
                    if (r_req == ksr_pkg::REQ_KEY_DOWN &&
                        list_stat.used < ksr_pkg::t_cnt'(ksr_pkg::KEY_SLOTS)) begin
                        list_ctrl.op = ksr_pkg::L_APPEND;
                    end
                end else if (!list_stat.hit) begin
                    n_idx = idx_inc;
                end
            end
            ksr_pkg::S_SHIFT: begin
                if (shift_more) begin
                    list_ctrl.op = ksr_pkg::L_SHIFT;
                    n_idx        = idx_inc;
                end else begin
                    list_ctrl.op = ksr_pkg::L_DROP;
                end
            end
            ksr_pkg::S_EMIT: begin
                out_load = out_free;
                n_m_data[87:80] = r_mods;
                n_m_data[90:88] = 3'(list_stat.used);
                if (r_req == ksr_pkg::REQ_OTHER) begin
                    n_m_kind        = ksr_pkg::KIND_OTHER;
                    n_m_data[79:32] = r_pl;
                end else begin
                    n_m_kind = (r_req == ksr_pkg::REQ_KEY_DOWN) ? ksr_pkg::KIND_KEY_DOWN
                                                                : ksr_pkg::KIND_KEY_UP;
                    n_m_data[7:0]   = r_sc;
                    n_m_data[23:8]  = r_vk;
                    n_m_data[31:24] = r_fl;
                end
            end
            ksr_pkg::S_FLUSH_UP: begin
                out_load        = out_free;
                n_m_kind        = ksr_pkg::KIND_ALL_UP;
                n_m_data[31:24] = ksr_pkg::ALL_UP_FLAGS;
                n_m_last        = 1'b0;
            end
            ksr_pkg::S_FLUSH_IDLE: begin
                out_load = out_free;
                n_m_kind = ksr_pkg::KIND_MOUSE_IDLE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ksr_pkg::S_IDLE;
            r_to_client <= 1'b0;
            r_link_up   <= 1'b0;
            r_mods      <= '0;
            r_idx       <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_to_client <= n_to_client;
            r_link_up   <= n_link_up;
            r_mods      <= n_mods;
            r_idx       <= n_idx;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_req <= in_req;
            r_sc  <= s_axis_tdata[7:0];
            r_vk  <= s_axis_tdata[23:8];
            r_fl  <= s_axis_tdata[31:24];
            r_pl  <= s_axis_tdata[79:32];
        end
        if (out_load) begin
            r_m_kind <= n_m_kind;
            r_m_data <= n_m_data;
            r_m_last <= n_m_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tlast  = r_m_last;

endmodule

### design/ksr_key_list.sv
// Held-key slot list with its single shared byte comparator.
// Depends on ksr_pkg.
`timescale 1ns / 1ps

module ksr_key_list (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ksr_pkg::t_list_ctrl i_ctrl,
    input  logic [7:0]          i_scan_code,
    output ksr_pkg::t_list_stat o_stat
);

    logic [7:0]    r_slot [ksr_pkg::KEY_SLOTS];
    ksr_pkg::t_cnt r_used;
    ksr_pkg::t_cnt rd_ptr;
    ksr_pkg::t_cnt nxt_idx;
    logic [7:0]    rd_data;

    assign nxt_idx = ksr_pkg::t_cnt'(i_ctrl.idx + ksr_pkg::t_cnt'(1));
    // shift reads the neighbour above, the compare reads the slot itself
    assign rd_ptr  = (i_ctrl.op == ksr_pkg::L_SHIFT) ? nxt_idx : i_ctrl.idx;
    assign rd_data = r_slot[rd_ptr[ksr_pkg::IDX_W-1:0]];

    assign o_stat.used = r_used;
    assign o_stat.hit  = (rd_data == i_scan_code);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            unique case (i_ctrl.op)
                ksr_pkg::L_CLEAR:  r_used <= '0;
                ksr_pkg::L_APPEND: r_used <= ksr_pkg::t_cnt'(r_used + ksr_pkg::t_cnt'(1));
                ksr_pkg::L_DROP:   r_used <= ksr_pkg::t_cnt'(r_used - ksr_pkg::t_cnt'(1));
                default:           r_used <= r_used;
            endcase
        end
    end

    // entries at or above the fill count are never compared, so no clearing
    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == ksr_pkg::L_APPEND) begin
            r_slot[r_used[ksr_pkg::IDX_W-1:0]] <= i_scan_code;
        end else if (i_ctrl.op == ksr_pkg::L_SHIFT) begin
            r_slot[i_ctrl.idx[ksr_pkg::IDX_W-1:0]] <= rd_data;
        end
    end

endmodule

### verif/keyboard_state_router_top_tb.sv
// Self-checking testbench for keyboard_state_router_top: a directed table, then random
// key, routing and link traffic, with a predictor of the client key state.
// Depends on ksr_pkg and the keyboard_state_router_top RTL.
`timescale 1ns / 1ps

module keyboard_state_router_top_tb;
    import ksr_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 420;
    localparam int DRAIN_CYCLES = 4 * KEY_SLOTS + 20;
    // mapped virtual keys, index = HID modifier bit
    localparam logic [7:0][15:0] MOD_VK = {16'h005C, 16'h00A5, 16'h00A1, 16'h00A3,
                                           16'h005B, 16'h00A4, 16'h00A0, 16'h00A2};

    typedef struct {
        t_kind       kind;
        logic [7:0]  sc;
        logic [15:0] vk;
        logic [7:0]  fl;
        logic [47:0] pl;
        logic [7:0]  mods;
        t_cnt        count;
        logic        last;
    } t_result;

    // n_typed < 0: results come from the predictor
    typedef struct {
        t_req        req;
        logic [7:0]  sc;
        logic [15:0] vk;
        logic [7:0]  fl;
        logic [47:0] pl;
        int          n_typed;
        logic [7:0]  mods;
        t_cnt        count;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // predicted client-side state
    bit          pr_to_client;
    bit          pr_link_up;
    logic [7:0]  pr_mods;
    int          pr_used;
    logic [7:0]  pr_slot [KEY_SLOTS];

    t_result     step_out [2];
    int          step_n;
    t_result     pending_results [$];
    int          errors = 0;
    bit          quiet = 1'b0;

    always #5 i_clk = ~i_clk;

    keyboard_state_router_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic logic [7:0] mod_bit_of(input logic [15:0] vk);
        logic [7:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
            if (MOD_VK[b] == vk) m[b] = 1'b1;
        return m;
    endfunction

    function automatic void leave_client();
        if (pr_to_client) begin
            pr_to_client = 1'b0;
            pr_mods = '0;
            pr_used = 0;
            foreach (pr_slot[i]) pr_slot[i] = '0;
            step_out[0] = '{KIND_ALL_UP, 8'd0, 16'd0, ALL_UP_FLAGS, 48'd0, 8'd0, '0, 1'b0};
            step_out[1] = '{KIND_MOUSE_IDLE, 8'd0, 16'd0, 8'd0, 48'd0, 8'd0, '0, 1'b1};
            step_n = 2;
        end
    endfunction

    // update the predicted state for one accepted event; results in step_out
    function automatic void route_event(input t_req r, input logic [79:0] d);
        logic [7:0]  sc;
        logic [15:0] vk;
        logic [7:0]  fl;
        logic [47:0] pl;
        logic [7:0]  m;
        int          hit;
        sc = d[7:0];
        vk = d[23:8];
        fl = d[31:24];
        pl = d[79:32];
        m = mod_bit_of(vk);
        hit = -1;
        step_n = 0;
        case (r)
            REQ_KEY_DOWN, REQ_KEY_UP: begin
                if (pr_to_client && pr_link_up) begin
                    for (int i = 0; i < pr_used; i++)
                        if (hit < 0 && pr_slot[i] == sc) hit = i;
                    if (r == REQ_KEY_DOWN) begin
                        pr_mods |= m;
                        if (hit < 0 && pr_used < KEY_SLOTS) begin
                            pr_slot[pr_used] = sc;
                            pr_used++;
                        end
                    end else begin
                        pr_mods &= ~m;
                        if (hit >= 0) begin
                            for (int j = hit; j < pr_used - 1; j++)
                                pr_slot[j] = pr_slot[j + 1];
                            pr_used--;
                            pr_slot[pr_used] = '0;
                        end
                    end
                    step_out[0] = '{(r == REQ_KEY_DOWN) ? KIND_KEY_DOWN : KIND_KEY_UP,
                                    sc, vk, fl, 48'd0, pr_mods, t_cnt'(pr_used), 1'b1};
                    step_n = 1;
                end
            end
            REQ_OTHER: begin
                if (pr_to_client && pr_link_up) begin
                    step_out[0] = '{KIND_OTHER, 8'd0, 16'd0, 8'd0, pl, pr_mods,
                                    t_cnt'(pr_used), 1'b1};
                    step_n = 1;
                end
            end
            REQ_TO_HOST: leave_client();
            REQ_TO_CLIENT: if (pr_link_up) pr_to_client = 1'b1;
            REQ_TOGGLE: begin
                if (pr_to_client) leave_client();
                else if (pr_link_up) pr_to_client = 1'b1;
            end
            REQ_CONNECT: pr_link_up = 1'b1;
            default: begin
                pr_link_up = 1'b0;
                pr_to_client = 1'b0;
            end
        endcase
    endfunction

    function automatic t_row mk_row(input t_req r, input logic [7:0] sc, input logic [15:0] vk,
                                    input logic [7:0] fl, input logic [47:0] pl,
                                    input int n, input logic [7:0] mods, input t_cnt count);
        t_row row;
        row = '{r, sc, vk, fl, pl, n, mods, count};
        return row;
    endfunction

    function automatic void cmp(input string field, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
            errors++;
        end
    endfunction

    // drive one event and return at the edge where the transfer happens
    task automatic send_item(input t_req r, input logic [79:0] d);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    always @(negedge i_clk)
        m_axis_tready <= quiet || ($urandom_range(99) >= 36);

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none actual kind %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                e = pending_results.pop_front();
                cmp("out_kind", e.kind, m_axis_tuser);
                cmp("out_scan_code", e.sc, m_axis_tdata[7:0]);
                cmp("out_virtual_key", e.vk, m_axis_tdata[23:8]);
                cmp("out_flags", e.fl, m_axis_tdata[31:24]);
                cmp("out_payload", e.pl, m_axis_tdata[79:32]);
                cmp("held_modifiers", e.mods, m_axis_tdata[87:80]);
                cmp("held_count", e.count, m_axis_tdata[90:88]);
                cmp("tdata padding", 0, m_axis_tdata[95:91]);
                cmp("last_of_run", e.last, m_axis_tlast);
            end
        end
    end

    // ends the run if no transfer happens on either side for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("keyboard_state_router_top verification failed");
        $finish;
    end

    initial begin : stimulus
        t_row        rows [$];
        t_req        r;
        logic [7:0]  sc;
        logic [15:0] vk;
        logic [7:0]  fl;
        logic [47:0] pl;
        logic [79:0] d;
        int          p;
        int          sent;
        bit          paused;

        pr_to_client = 1'b0;
        pr_link_up = 1'b0;
        pr_mods = '0;
        pr_used = 0;
        foreach (pr_slot[i]) pr_slot[i] = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // out of reset: host routing, no client, so everything is dropped until connect and to_client
        rows.push_back(mk_row(REQ_KEY_DOWN, 8'h00, 16'h00A2, 8'h00, 48'd0, 0, 8'h00, 0));
        rows.push_back(mk_row(REQ_OTHER, 8'hFF, 16'hFFFF, 8'hFF, '1, 0, 8'h00, 0));
        rows.push_back(mk_row(REQ_TO_CLIENT, 8'h00, 16'h0000, 8'h00, 48'd0, 0, 8'h00, 0));
        rows.push_back(mk_row(REQ_TO_HOST, 8'h00, 16'h0000, 8'h00, 48'd0, 0, 8'h00, 0));
        rows.push_back(mk_row(REQ_CONNECT, 8'h00, 16'h0000, 8'h00, 48'd0, 0, 8'h00, 0));
        rows.push_back(mk_row(REQ_TO_CLIENT, 8'h00, 16'h0000, 8'h00, 48'd0, 0, 8'h00, 0));
        rows.push_back(mk_row(REQ_KEY_DOWN, 8'h00, 16'h00A2, 8'h00, '1, 1, 8'h01, 1));
        rows.push_back(mk_row(REQ_KEY_DOWN, 8'hFF, 16'h005B, 8'hFF, 48'd0, 1, 8'h09, 2));
        // repeated scan code: modifier set, list untouched
        rows.push_back(mk_row(REQ_KEY_DOWN, 8'hFF, 16'h005C, 8'h5A, 48'd0, 1, 8'h89, 2));
        rows.push_back(mk_row(REQ_KEY_DOWN, 8'h10, 16'h00A0, 8'h01, 48'd0, -1, 8'h00, 0));
        rows.push_back(mk_row(REQ_KEY_DOWN, 8'h11, 16'h00A1, 8'h02, 48'd0, -1, 8'h00, 0));
        rows.push_back(mk_row(REQ_KEY_DOWN, 8'h12, 16'h00A3, 8'h04, 48'd0, -1, 8'h00, 0));
        rows.push_back(mk_row(REQ_KEY_DOWN, 8'h13, 16'h00A4, 8'h08, 48'd0, -1, 8'h00, 0));
        // list full: forwarded, not tracked
        rows.push_back(mk_row(REQ_KEY_DOWN, 8'h14, 16'h00A5, 8'h10, 48'd0, -1, 8'h00, 0));
        // untracked, unmapped key up
        rows.push_back(mk_row(REQ_KEY_UP, 8'h99, 16'hFFFF, 8'h20, 48'd0, -1, 8'h00, 0));
        rows.push_back(mk_row(REQ_KEY_UP, 8'h00, 16'h00A2, 8'h40, 48'd0, -1, 8'h00, 0));
        rows.push_back(mk_row(REQ_KEY_UP, 8'h12, 16'h005B, 8'h80, 48'd0, -1, 8'h00, 0));
        rows.push_back(mk_row(REQ_OTHER, 8'h00, 16'h0000, 8'h00, '1, -1, 8'h00, 0));
        rows.push_back(mk_row(REQ_TO_HOST, 8'h00, 16'h0000, 8'h00, 48'd0, 2, 8'h00, 0));
        rows.push_back(mk_row(REQ_TOGGLE, 8'h00, 16'h0000, 8'h00, 48'd0, 0, 8'h00, 0));
        rows.push_back(mk_row(REQ_KEY_DOWN, 8'h55, 16'hFFFF, 8'hAA, 48'h123456789ABC, 1,
                              8'h00, 1));
        // disconnect drops routing without a flush but keeps the held keys
        rows.push_back(mk_row(REQ_DISCONNECT, 8'h00, 16'h0000, 8'h00, 48'd0, 0, 8'h00, 0));
        rows.push_back(mk_row(REQ_KEY_UP, 8'h55, 16'hFFFF, 8'h00, 48'd0, 0, 8'h00, 0));
        rows.push_back(mk_row(REQ_CONNECT, 8'h00, 16'h0000, 8'h00, 48'd0, 0, 8'h00, 0));
        rows.push_back(mk_row(REQ_TOGGLE, 8'h00, 16'h0000, 8'h00, 48'd0, 0, 8'h00, 0));
        rows.push_back(mk_row(REQ_TOGGLE, 8'h00, 16'h0000, 8'h00, 48'd0, 2, 8'h00, 0));

        foreach (rows[k]) begin
            d = {rows[k].pl, rows[k].fl, rows[k].vk, rows[k].sc};
            send_item(rows[k].req, d);
            route_event(rows[k].req, d);
            if (rows[k].n_typed < 0) begin
                for (int i = 0; i < step_n; i++) pending_results.push_back(step_out[i]);
            end else if (rows[k].n_typed == 2) begin
                pending_results.push_back('{KIND_ALL_UP, 8'd0, 16'd0, 8'hFF, 48'd0, 8'd0,
                                            '0, 1'b0});
                pending_results.push_back('{KIND_MOUSE_IDLE, 8'd0, 16'd0, 8'd0, 48'd0, 8'd0,
                                            '0, 1'b1});
            end else if (rows[k].n_typed == 1) begin
                pending_results.push_back('{(rows[k].req == REQ_KEY_DOWN) ? KIND_KEY_DOWN
                                                                           : KIND_KEY_UP,
                                            rows[k].sc, rows[k].vk, rows[k].fl, 48'd0,
                                            rows[k].mods, rows[k].count, 1'b1});
            end
        end

        sent = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            p = $urandom_range(99);
            if (!(pr_to_client && pr_link_up)) begin
                // mostly get back into client mode, the rest is noise
                if (p < 30)      r = REQ_CONNECT;
                else if (p < 60) r = REQ_TO_CLIENT;
                else if (p < 70) r = REQ_TOGGLE;
                else             r = t_req'($urandom_range(7));
            end else begin
                if (p < 38)      r = REQ_KEY_DOWN;
                else if (p < 70) r = REQ_KEY_UP;
                else if (p < 80) r = REQ_OTHER;
                else if (p < 84) r = REQ_TO_HOST;
                else if (p < 88) r = REQ_TOGGLE;
                else if (p < 92) r = REQ_TO_CLIENT;
                else if (p < 96) r = REQ_CONNECT;
                else             r = REQ_DISCONNECT;
            end
            if ($urandom_range(99) < 70) sc = 8'($urandom_range(9));
            else                         sc = 8'($urandom);
            // key ups mostly release something that is held
            if (r == REQ_KEY_UP && pr_used > 0 && $urandom_range(99) < 60)
                sc = pr_slot[$urandom_range(pr_used - 1)];
            if ($urandom_range(1)) vk = MOD_VK[$urandom_range(7)];
            else                   vk = 16'($urandom);
            fl = 8'($urandom);
            pl = 48'({$urandom, $urandom});
            d = {pl, fl, vk, sc};

            send_item(r, d);
            route_event(r, d);
            for (int i = 0; i < step_n; i++) pending_results.push_back(step_out[i]);
            sent++;

            quiet = (sent >= 250 && sent < 330);
            // hold the sender off once until every result is out
            if (!paused && sent >= 150) begin
                paused = 1'b1;
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("keyboard_state_router_top verification clean");
        else
            $display("keyboard_state_router_top verification failed");
        $finish;
    end

endmodule
